FILE: rtl/f16cv_pkg.sv
`timescale 1ns / 1ps

package f16cv_pkg;

  localparam int SINGLE_W = 32;
  localparam int HALF_W   = 16;

  // conversion direction carried in tuser
  typedef logic [0:0] cmd_t;
  localparam cmd_t CMD_S2H = 1'b0;
  localparam cmd_t CMD_H2S = 1'b1;

  typedef logic [SINGLE_W-1:0] single_t;
  typedef logic [HALF_W-1:0]   half_t;

endpackage

FILE: rtl/f16cv_s2h.sv
`timescale 1ns / 1ps

module f16cv_s2h (
  input  f16cv_pkg::single_t operand,
  output f16cv_pkg::half_t   result
);
  import f16cv_pkg::*;

  logic        sign;
  logic [7:0]  expo;
  logic [22:0] mant;
  logic [7:0]  sh_wide;
  logic [4:0]  sh;
  logic [23:0] denorm;
  logic [7:0]  e_norm;

  assign sign    = operand[31];
  assign expo    = operand[30:23];
  assign mant    = operand[22:0];
  // shift for the denormal range, 14..24
  assign sh_wide = 8'd126 - expo;
  assign sh      = sh_wide[4:0];
  assign denorm  = {1'b1, mant} >> sh;
  assign e_norm  = expo - 8'd112;

  always_comb begin
    if (expo == 8'd0) begin
      result = {sign, 15'd0};
    end else if (expo == 8'hFF) begin
      result = {sign, 5'h1F, (mant != 23'd0), 9'd0};
    end else if (expo >= 8'd143) begin
      // overflow to infinity
      result = {sign, 5'h1F, 10'd0};
    end else if (expo <= 8'd112) begin
      if (expo >= 8'd102) begin
        result = {sign, 5'd0, denorm[9:0]};
      end else begin
        result = {sign, 15'd0};
      end
    end else begin
      result = {sign, e_norm[4:0], mant[22:13]};
    end
  end

endmodule

FILE: rtl/f16cv_h2s.sv
`timescale 1ns / 1ps

module f16cv_h2s (
  input  f16cv_pkg::half_t   operand,
  output f16cv_pkg::single_t result
);
  import f16cv_pkg::*;

  logic        sign;
  logic [4:0]  expo;
  logic [9:0]  mant;
  logic [3:0]  lz;
  logic [10:0] norm;
  logic [7:0]  e_sub;

  assign sign = operand[15];
  assign expo = operand[14:10];
  assign mant = operand[9:0];

  // leading-zero count over the ten mantissa bits, highest set bit wins
  always_comb begin
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (mant[i]) begin
        lz = 4'(9 - i);
      end
    end
  end

  assign norm  = {1'b0, mant} << (lz + 4'd1);
  assign e_sub = 8'd112 - {4'd0, lz};

  always_comb begin
    if (expo == 5'd0) begin
      if (mant == 10'd0) begin
        result = {sign, 31'd0};
      end else begin
        result = {sign, e_sub, norm[9:0], 13'd0};
      end
    end else if (expo == 5'h1F) begin
      result = {sign, 8'hFF, mant, 13'd0};
    end else begin
      result = {sign, {3'd0, expo} + 8'd112, mant, 13'd0};
    end
  end

endmodule

FILE: rtl/fp32_fp16_converter_top.sv
`timescale 1ns / 1ps

// ieee single <-> half bit-pattern converter, direction chosen per transaction by tuser
// (0 = single to half, 1 = half to single). single to half truncates the mantissa,
// flushes single zeros and denormals to signed zero, saturates overflow to signed
// infinity, makes half denormals for small exponents and turns any nan into a quiet
// nan with only mantissa bit 9 set. half to single is exact; input bits 31..16 are
// ignored there. a half result sits in tdata[15:0] with tdata[31:16] zero.
// throughput is one transaction per cycle while m_axis_tready keeps the result register
// draining. an accepted transaction lands in the input register, passes the single pass
// of conversion logic and is loaded into the result register once that register has room,
// where it is held until m_axis_tready takes it.
module fp32_fp16_converter_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  f16cv_pkg::single_t    s_axis_tdata,  // [31:0] operand_bits
  input  f16cv_pkg::cmd_t       s_axis_tuser,  // [0] cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output f16cv_pkg::single_t    m_axis_tdata   // [31:0] result_bits
);
  import f16cv_pkg::*;

  // input register stage
  logic    in_valid;
  cmd_t    in_cmd;
  single_t in_bits;

  // result register stage
  logic    out_valid;
  single_t out_bits;

  logic    adv_out;
  logic    adv_in;
  half_t   s2h_result;
  single_t h2s_result;
  single_t result_next;

  // each stage moves when its successor has room
  assign adv_out       = !out_valid || m_axis_tready;
  assign adv_in        = !in_valid || adv_out;
  assign s_axis_tready = adv_in;

  f16cv_s2h u_s2h (
    .operand (in_bits),
    .result  (s2h_result)
  );

  f16cv_h2s u_h2s (
    .operand (in_bits[HALF_W-1:0]),
    .result  (h2s_result)
  );

  always_comb begin
    unique case (in_cmd)
      CMD_S2H: result_next = {{(SINGLE_W-HALF_W){1'b0}}, s2h_result};
      CMD_H2S: result_next = h2s_result;
      default: result_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv_in) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && s_axis_tvalid) begin
      in_cmd  <= s_axis_tuser;
      in_bits <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && in_valid) begin
      out_bits <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_bits;

  // a held item in the input stage is never dropped while the output stalls
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !adv_out |=> in_valid && $stable(in_bits) && $stable(in_cmd))
    else $error("input stage lost an item under backpressure");

  // single to half results always have a zero upper half
  assert property (@(posedge clk) disable iff (rst)
    in_valid && adv_out && (in_cmd == CMD_S2H) |=> m_axis_tdata[31:16] == 16'd0)
    else $error("half result has nonzero upper bits");

  // an empty result register never blocks the input side
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // every item in the input stage reaches the result register when it moves
  assert property (@(posedge clk) disable iff (rst)
    in_valid && adv_out |=> out_valid)
    else $error("item vanished between stages");

endmodule

FILE: tb/sv/fp32_fp16_converter_top_test.sv
`timescale 1ns / 1ps

module fp32_fp16_converter_top_test;
  import f16cv_pkg::*;

  localparam int N_RANDOM   = 1500;
  localparam int N_DIRECTED = 25;
  localparam int MAX_IDLE   = 8;
  localparam int TAIL_WAIT  = 6;  // result path is two registers deep

  logic    clk;
  logic    rst;
  logic    s_axis_tvalid;
  logic    s_axis_tready;
  single_t s_axis_tdata;   // [31:0] operand_bits
  cmd_t    s_axis_tuser;   // [0] cmd
  logic    m_axis_tvalid;
  logic    m_axis_tready;
  single_t m_axis_tdata;   // [31:0] result_bits

  fp32_fp16_converter_top uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // one directed row: direction, operand, and a hand-typed result where it is obvious
  typedef struct {
    cmd_t    dir;
    single_t operand;
    bit      typed;
    single_t want;
  } conv_vector_t;

  conv_vector_t directed_rows [N_DIRECTED] = '{
    // single to half: zeros and denormals flush to signed zero
    '{CMD_S2H, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{CMD_S2H, 32'h8000_0000, 1'b1, 32'h0000_8000},
    '{CMD_S2H, 32'h007F_FFFF, 1'b1, 32'h0000_0000},
    '{CMD_S2H, 32'h807F_FFFF, 1'b1, 32'h0000_8000},
    // infinities and nans (nan payload replaced by the quiet bit)
    '{CMD_S2H, 32'h7F80_0000, 1'b1, 32'h0000_7C00},
    '{CMD_S2H, 32'hFF80_0000, 1'b1, 32'h0000_FC00},
    '{CMD_S2H, 32'h7FC0_0001, 1'b1, 32'h0000_7E00},
    '{CMD_S2H, 32'hFFFF_FFFF, 1'b1, 32'h0000_FE00},
    // overflow: largest single, then the first exponent past half range
    '{CMD_S2H, 32'h7F7F_FFFF, 1'b1, 32'h0000_7C00},
    '{CMD_S2H, 32'h4780_0000, 1'b1, 32'h0000_7C00},
    // largest exponent that still fits, one, and the denormal band edges
    '{CMD_S2H, 32'h477F_FFFF, 1'b0, 32'h0},
    '{CMD_S2H, 32'h3F80_0000, 1'b0, 32'h0},
    '{CMD_S2H, 32'h3800_0000, 1'b0, 32'h0},
    '{CMD_S2H, 32'hB37F_FFFF, 1'b0, 32'h0},
    // just below the denormal range
    '{CMD_S2H, 32'h32FF_FFFF, 1'b1, 32'h0000_0000},
    // half to single: zeros, infinities
    '{CMD_H2S, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{CMD_H2S, 32'h0000_8000, 1'b1, 32'h8000_0000},
    '{CMD_H2S, 32'h0000_7C00, 1'b1, 32'h7F80_0000},
    '{CMD_H2S, 32'h0000_FC00, 1'b1, 32'hFF80_0000},
    // denormals, largest normal, signaling nan kept as is
    '{CMD_H2S, 32'h0000_0001, 1'b0, 32'h0},
    '{CMD_H2S, 32'h0000_83FF, 1'b0, 32'h0},
    '{CMD_H2S, 32'h0000_7BFF, 1'b0, 32'h0},
    '{CMD_H2S, 32'h0000_7D01, 1'b0, 32'h0},
    // upper operand bits must be ignored
    '{CMD_H2S, 32'hFFFF_3C00, 1'b0, 32'h0},
    '{CMD_H2S, 32'hFFFF_0000, 1'b1, 32'h0000_0000}
  };

  single_t pending_results[$];  // converted patterns still owed by the block
  int      errors;
  int      n_s2h;
  int      n_h2s;
  int      n_checked;
  bit      tx_steady;
  bit      rx_steady;

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // single to half, truncating
  function automatic half_t single_to_half_bits(single_t v);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] full;
    logic [23:0] shifted;
    int          e;
    sgn = v[31];
    ex  = v[30:23];
    man = v[22:0];
    if (ex == 8'h00) return {sgn, 15'h0};
    if (ex == 8'hFF) return {sgn, 5'h1F, (man != 23'h0) ? 10'h200 : 10'h000};
    e = int'(ex) - 112;  // rebias 127 -> 15
    if (e >= 31) return {sgn, 5'h1F, 10'h000};
    if (e <= 0) begin
      if (e < -10) return {sgn, 15'h0};
      // half denormal: hidden bit restored, shifted down and truncated
      full    = {1'b1, man};
      shifted = full >> (14 - e);
      return {sgn, 5'h00, shifted[9:0]};
    end
    return {sgn, e[4:0], man[22:13]};
  endfunction

  // half to single, exact
  function automatic single_t half_to_single_bits(half_t h);
    logic       sgn;
    logic [4:0] ex;
    logic [9:0] man;
    int         lz;
    sgn = h[15];
    ex  = h[14:10];
    man = h[9:0];
    lz  = 0;
    if (ex == 5'h00) begin
      if (man == 10'h000) return {sgn, 31'h0};
      // normalize: find the leading one, then drop it as the hidden bit
      while (!man[9]) begin
        man = man << 1;
        lz++;
      end
      man = man << 1;
      return {sgn, 8'(112 - lz), man, 13'h0};
    end
    if (ex == 5'h1F) return {sgn, 8'hFF, man, 13'h0};
    return {sgn, 8'(int'(ex) + 112), man, 13'h0};
  endfunction

  function automatic single_t convert_pattern(cmd_t dir, single_t operand);
    if (dir == CMD_S2H) return {16'h0, single_to_half_bits(operand)};
    return half_to_single_bits(operand[15:0]);
  endfunction

  // random operand, weighted toward the interesting exponent bands
  function automatic single_t random_operand(cmd_t dir);
    logic [9:0] hman;
    int         sel;
    sel = $urandom_range(0, 4);
    if (dir == CMD_S2H) begin
      case (sel)
        0, 1: begin
          return $urandom();
        end
        2, 3: begin
          // around the denormal, normal and overflow boundaries of half
          return {1'($urandom()), 8'($urandom_range(98, 146)), 23'($urandom())};
        end
        default: begin
          // zero/denormal or inf/nan exponent, sometimes with a clean mantissa
          return {1'($urandom()), ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
                  ($urandom_range(0, 3) == 0) ? 23'h0 : 23'($urandom())};
        end
      endcase
    end
    hman = 10'($urandom()) >> $urandom_range(0, 9);
    case (sel)
      0, 1: begin
        return $urandom();
      end
      2: begin
        // half denormals spread over every leading-zero count
        return {16'($urandom()), 1'($urandom()), 5'h00, hman};
      end
      3: begin
        return {16'($urandom()), 1'($urandom()), 5'h1F, 10'($urandom())};
      end
      default: begin
        return {16'($urandom()), 1'($urandom()), 5'($urandom_range(1, 30)),
                10'($urandom())};
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  // offers one operand and returns once the block has taken it
  task automatic send_operand(cmd_t dir, single_t operand, bit typed, single_t want);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= operand;
    s_axis_tuser  <= dir;
    do @(posedge clk); while (!s_axis_tready);
    // transaction accepted at this edge
    pending_results.push_back(typed ? want : convert_pattern(dir, operand));
    if (dir == CMD_S2H) n_s2h++;
    else n_h2s++;
  endtask

  // stop offering and hold off until every owed result has been delivered
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, in-order compare
  // ---------------------------------------------------------------------------

  task automatic collect_results();
    int      stall;
    single_t want;
    forever begin
      if ((n_checked % 100) == 0) rx_steady = ($urandom_range(0, 3) == 0);
      stall = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      n_checked++;
      if (pending_results.size() == 0) begin
        $error("result_bits: unexpected transaction, actual %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want) begin
          $error("result_bits mismatch: expected %h, actual %h", want, m_axis_tdata);
          errors++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    cmd_t dir;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_S2H;
    m_axis_tready = 1'b0;
    errors        = 0;
    n_s2h         = 0;
    n_h2s         = 0;
    n_checked     = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    fork
      collect_results();
    join_none

    // directed table: boundaries, special values, both directions
    foreach (directed_rows[i])
      send_operand(directed_rows[i].dir, directed_rows[i].operand,
                   directed_rows[i].typed, directed_rows[i].want);

    // let the pipeline empty before the random mix
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      // alternate between gappy traffic and back-to-back bursts
      if ((i % 100) == 0) tx_steady = ($urandom_range(0, 3) == 0);
      // one full hold-off halfway through
      if (i == N_RANDOM / 2) drain_results();
      dir = ($urandom_range(0, 1) != 0) ? CMD_H2S : CMD_S2H;
      send_operand(dir, random_operand(dir), 1'b0, '0);
    end

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("covered %0d single-to-half and %0d half-to-single conversions,",
             n_s2h, n_h2s);
    $display("%0d results compared, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
